[src/assert_macros.svh]
// Assertion helpers for the queue RTL.
// CHK_IMPL: same-cycle implication, CHK_NEXT: next-cycle implication.
// Both expect clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("queue check failed");
`define CHK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("queue check failed");
`else
`define CHK_IMPL(lbl, pre, post)
`define CHK_NEXT(lbl, pre, post)
`endif
`endif

[src/prsq_pkg.sv]
package prsq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int PID_W           = 16;
  localparam int TIME_W          = 32;
  localparam int CMD_W           = 2;
  localparam int COUNT_OUT_W     = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ      = 2'd0,
    CMD_DEQ      = 2'd1,
    CMD_SORT_REM = 2'd2,
    CMD_SORT_EXE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] exe;
  } rec_t;

  typedef struct packed {
    cell_op_t op;
    logic     by_exe;
  } cell_ctrl_t;

  // True when record a belongs behind record b in the selected order
  function automatic logic goes_after(logic by_exe, rec_t a, rec_t b);
    logic res;
    if (by_exe) begin
      res = (a.exe < b.exe);
    end else if (a.rem != b.rem) begin
      res = (a.rem > b.rem);
    end else begin
      res = (a.pid > b.pid);
    end
    return res;
  endfunction

endpackage

[src/process_record_sort_queue.sv]
// Process record queue: a row of QUEUE_DEPTH record cells, front at cell 0.
// Enqueue and dequeue may be issued back to back; the result register can
// transfer in the same cycle that the next command is taken, and a stalled
// result holds off the input until it transfers. A sort command (by
// remaining time then id, or by execution time descending; both stable)
// runs an odd-even transposition over the row, one compare-exchange phase
// per cycle, for as many phases as records are held (none for zero or one
// record), so it occupies the block and stalls the input meanwhile. Every
// command yields exactly one result carrying the record count after the
// command.
`include "assert_macros.svh"

module process_record_sort_queue #(
  parameter int QUEUE_DEPTH = prsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [prsq_pkg::CMD_W-1:0]          in_cmd,
  input  logic [prsq_pkg::PID_W-1:0]          in_process_id,
  input  logic [prsq_pkg::TIME_W-1:0]         in_remaining_time,
  input  logic [prsq_pkg::TIME_W-1:0]         in_execution_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_item_valid,
  output logic [prsq_pkg::PID_W-1:0]          out_process_id,
  output logic [prsq_pkg::TIME_W-1:0]         out_remaining_time,
  output logic [prsq_pkg::TIME_W-1:0]         out_execution_time,
  output logic                                out_error_flag,
  output logic [prsq_pkg::COUNT_OUT_W-1:0]    out_queue_count
);
  import prsq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ST_RUN,
    ST_SORT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] phase_cnt_r;
  logic             phase_r;
  logic             by_exe_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_item_valid_r;
  logic             out_error_r;
  rec_t             out_rec_r;

  cmd_t       cmd;
  logic       in_fire;
  logic       out_fire;
  logic       full;
  logic       empty;
  rec_t       in_rec;
  cell_ctrl_t cell_ctrl;
  rec_t       cell_rec [QUEUE_DEPTH];

  assign cmd      = cmd_t'(in_cmd);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign in_stall = (state_r == ST_SORT) || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  assign in_rec.pid = in_process_id;
  assign in_rec.rem = in_remaining_time;
  assign in_rec.exe = in_execution_time;

  // Drive the row: sort phase, or the operation of the accepted command
  always_comb begin
    cell_ctrl.op     = OP_HOLD;
    cell_ctrl.by_exe = by_exe_r;
    if (state_r == ST_SORT) begin
      cell_ctrl.op = OP_SORT;
    end else if (in_fire) begin
      unique case (cmd)
        CMD_ENQ: begin
          if (!full) begin
            cell_ctrl.op = OP_LOAD;
          end
        end
        CMD_DEQ: begin
          if (!empty) begin
            cell_ctrl.op = OP_SHIFT;
          end
        end
        default: begin
          cell_ctrl.op = OP_HOLD;
        end
      endcase
    end
  end

  // Hold a result until its transfer; raise it when a command completes
  always_comb begin
    out_valid_nxt = out_valid_r && !out_fire;
    if (state_r == ST_SORT) begin
      if (phase_cnt_r == CNT_W'(1)) begin
        out_valid_nxt = 1'b1;
      end
    end else if (in_fire) begin
      if ((cmd == CMD_ENQ) || (cmd == CMD_DEQ) || (count_r <= CNT_W'(1))) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  // Record cells with their neighbor links
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;
    logic sel;
    logic lower;
    logic lo_ok;
    logic hi_ok;

    assign sel   = (count_r == CNT_W'(i));
    assign lower = (phase_r == 1'(i % 2));
    assign lo_ok = (count_r > CNT_W'(i + 1));
    assign hi_ok = (i != 0) && (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_rec = cell_rec[i];
    end else begin : g_left
      assign left_rec = cell_rec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_right
      assign right_rec = cell_rec[i+1];
    end

    prsq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .sel       (sel),
      .lower     (lower),
      .lo_ok     (lo_ok),
      .hi_ok     (hi_ok),
      .load_rec  (in_rec),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .rec       (cell_rec[i])
    );
  end

  // Control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      phase_cnt_r <= '0;
      phase_r     <= 1'b0;
      by_exe_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_RUN: begin
          if (in_fire) begin
            out_rec_r        <= '0;
            out_item_valid_r <= 1'b0;
            out_error_r      <= 1'b0;
            unique case (cmd)
              CMD_ENQ: begin
                if (full) begin
                  out_error_r <= 1'b1;
                end else begin
                  count_r <= count_r + CNT_W'(1);
                end
              end
              CMD_DEQ: begin
                if (empty) begin
                  out_error_r <= 1'b1;
                end else begin
                  out_item_valid_r <= 1'b1;
                  out_rec_r        <= cell_rec[0];
                  count_r          <= count_r - CNT_W'(1);
                end
              end
              default: begin
                by_exe_r <= (cmd == CMD_SORT_EXE);
                if (count_r > CNT_W'(1)) begin
                  state_r     <= ST_SORT;
                  phase_cnt_r <= count_r;
                  phase_r     <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_SORT: begin
          // advance one transposition phase per cycle
          phase_r     <= ~phase_r;
          phase_cnt_r <= phase_cnt_r - CNT_W'(1);
          if (phase_cnt_r == CNT_W'(1)) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item_valid     = out_item_valid_r;
  assign out_process_id     = out_rec_r.pid;
  assign out_remaining_time = out_rec_r.rem;
  assign out_execution_time = out_rec_r.exe;
  assign out_error_flag     = out_error_r;
  assign out_queue_count    = COUNT_OUT_W'(count_r);

  `CHK_IMPL(a_count_max, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `CHK_IMPL(a_sort_needs_two, state_r == ST_SORT, count_r > CNT_W'(1))
  `CHK_NEXT(a_sort_count_held, state_r == ST_SORT, $stable(count_r))
  `CHK_NEXT(a_enq_grows, in_fire && cmd == CMD_ENQ && !full, count_r == $past(count_r) + CNT_W'(1))
  `CHK_IMPL(a_item_no_error, out_valid_r && out_item_valid_r, !out_error_r)

endmodule

[src/prsq_cell.sv]
module prsq_cell (
  input  logic                clk,
  input  prsq_pkg::cell_ctrl_t ctrl,
  input  logic                sel,
  input  logic                lower,
  input  logic                lo_ok,
  input  logic                hi_ok,
  input  prsq_pkg::rec_t      load_rec,
  input  prsq_pkg::rec_t      left_rec,
  input  prsq_pkg::rec_t      right_rec,
  output prsq_pkg::rec_t      rec
);
  import prsq_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;

  // Pick the next record: load, shift toward the front, or compare-exchange
  always_comb begin
    rec_nxt = rec_r;
    unique case (ctrl.op)
      OP_LOAD: begin
        if (sel) begin
          rec_nxt = load_rec;
        end
      end
      OP_SHIFT: begin
        rec_nxt = right_rec;
      end
      OP_SORT: begin
        if (lower) begin
          // front member of the pair keeps the earlier record
          if (lo_ok && goes_after(ctrl.by_exe, rec_r, right_rec)) begin
            rec_nxt = right_rec;
          end
        end else if (hi_ok && goes_after(ctrl.by_exe, left_rec, rec_r)) begin
          rec_nxt = left_rec;
        end
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

[tb/sv/prsq_checker.sv]
`timescale 1ns / 1ps

module prsq_checker
  import prsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [PID_W-1:0]       in_process_id,
  input  logic [TIME_W-1:0]      in_remaining_time,
  input  logic [TIME_W-1:0]      in_execution_time,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_item_valid,
  input  logic [PID_W-1:0]       out_process_id,
  input  logic [TIME_W-1:0]      out_remaining_time,
  input  logic [TIME_W-1:0]      out_execution_time,
  input  logic                   out_error_flag,
  input  logic [COUNT_OUT_W-1:0] out_queue_count,
  output int                     mismatch_count,
  output int                     results_owed
);

  typedef struct packed {
    logic                   item_valid;
    logic [PID_W-1:0]       pid;
    logic [TIME_W-1:0]      rem;
    logic [TIME_W-1:0]      exe;
    logic                   err;
    logic [COUNT_OUT_W-1:0] count;
  } queue_result_t;

  // Shadow of the held records, front first
  rec_t          held_recs[$];
  // Results owed by the block, oldest first
  queue_result_t due_results[$];

  // True when record a must sit behind record b in the chosen order
  function automatic logic ranks_behind(logic by_exe, rec_t a, rec_t b);
    if (by_exe) begin
      return a.exe < b.exe;
    end
    if (a.rem != b.rem) begin
      return a.rem > b.rem;
    end
    return a.pid > b.pid;
  endfunction

  // Apply one command to the shadow queue and build its result
  function automatic queue_result_t apply_command(cmd_t c, rec_t incoming);
    queue_result_t r;
    rec_t          swap;
    int            j;
    r = '0;
    case (c)
      CMD_ENQ: begin
        if (held_recs.size() >= QUEUE_DEPTH) begin
          r.err = 1'b1;
        end else begin
          held_recs.push_back(incoming);
        end
      end
      CMD_DEQ: begin
        if (held_recs.size() == 0) begin
          r.err = 1'b1;
        end else begin
          swap = held_recs.pop_front();
          r.item_valid = 1'b1;
          r.pid = swap.pid;
          r.rem = swap.rem;
          r.exe = swap.exe;
        end
      end
      default: begin
        // Stable insertion sort: equal keys never swap
        for (int i = 1; i < held_recs.size(); i++) begin
          j = i;
          while (j > 0 && ranks_behind(c == CMD_SORT_EXE, held_recs[j-1], held_recs[j])) begin
            swap = held_recs[j-1];
            held_recs[j-1] = held_recs[j];
            held_recs[j] = swap;
            j--;
          end
        end
      end
    endcase
    r.count = COUNT_OUT_W'(held_recs.size());
    return r;
  endfunction

  task automatic compare_field(string field, logic [TIME_W-1:0] want,
                               logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_command(cmd_t'(in_cmd),
          '{pid: in_process_id, rem: in_remaining_time, exe: in_execution_time}));
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          compare_field("item_valid", want.item_valid, out_item_valid);
          compare_field("process_id", want.pid, out_process_id);
          compare_field("remaining_time", want.rem, out_remaining_time);
          compare_field("execution_time", want.exe, out_execution_time);
          compare_field("error_flag", want.err, out_error_flag);
          compare_field("queue_count", want.count, out_queue_count);
        end
      end
      results_owed = due_results.size();
    end
  end

endmodule

[tb/sv/tb_process_record_sort_queue.sv]
`timescale 1ns / 1ps

module tb_process_record_sort_queue;
  import prsq_pkg::*;

  localparam int DEPTH            = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT      = 750000;
  localparam int GAP_CAP          = 16;
  localparam int RANDOM_PER_PHASE = 375;

  typedef enum int {WALK_FILL, WALK_DRAIN, WALK_MIXED} walk_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_cmd;
  logic [PID_W-1:0]       in_process_id;
  logic [TIME_W-1:0]      in_remaining_time;
  logic [TIME_W-1:0]      in_execution_time;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_item_valid;
  logic [PID_W-1:0]       out_process_id;
  logic [TIME_W-1:0]      out_remaining_time;
  logic [TIME_W-1:0]      out_execution_time;
  logic                   out_error_flag;
  logic [COUNT_OUT_W-1:0] out_queue_count;

  int fail_count;
  int results_owed;
  int cycle_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_stall_run;
  int fill_level;
  int n_enq, n_deq, n_sort, n_full_tries, n_empty_tries;
  int tx_phase_pct[4] = '{0, 45, 0, 27};
  int rx_phase_pct[4] = '{0, 0, 45, 27};
  walk_t walk;

  process_record_sort_queue dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_process_id      (in_process_id),
    .in_remaining_time  (in_remaining_time),
    .in_execution_time  (in_execution_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_valid     (out_item_valid),
    .out_process_id     (out_process_id),
    .out_remaining_time (out_remaining_time),
    .out_execution_time (out_execution_time),
    .out_error_flag     (out_error_flag),
    .out_queue_count    (out_queue_count)
  );

  prsq_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_process_id      (in_process_id),
    .in_remaining_time  (in_remaining_time),
    .in_execution_time  (in_execution_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_valid     (out_item_valid),
    .out_process_id     (out_process_id),
    .out_remaining_time (out_remaining_time),
    .out_execution_time (out_execution_time),
    .out_error_flag     (out_error_flag),
    .out_queue_count    (out_queue_count),
    .mismatch_count     (fail_count),
    .results_owed       (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result channel at random, capping each stall run
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    if (rx_stall_run < GAP_CAP && $urandom_range(0, 99) < rx_stall_pct) begin
      out_stall = 1'b1;
      rx_stall_run++;
    end else begin
      out_stall = 1'b0;
      rx_stall_run = 0;
    end
  end

  // Mix of tie-prone small values, corner values and full-range values
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0: return TIME_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return TIME_W'(1);
          2: return {{(TIME_W-1){1'b1}}, 1'b0};
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    case ($urandom_range(0, 3))
      0: return PID_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return PID_W'($urandom);
    endcase
  endfunction

  // Steer the fill level so both the full and the empty queue are reached
  function automatic cmd_t pick_cmd(walk_t w);
    int roll;
    int enq_lim, deq_lim;
    roll = $urandom_range(0, 99);
    case (w)
      WALK_FILL: begin
        enq_lim = 70;
        deq_lim = 82;
      end
      WALK_DRAIN: begin
        enq_lim = 12;
        deq_lim = 82;
      end
      default: begin
        enq_lim = 38;
        deq_lim = 76;
      end
    endcase
    if (roll < enq_lim) return CMD_ENQ;
    if (roll < deq_lim) return CMD_DEQ;
    if (roll < 91) return CMD_SORT_REM;
    return CMD_SORT_EXE;
  endfunction

  // Present one command at the falling edge and hold it until transfer
  task automatic issue_cmd(cmd_t c, logic [PID_W-1:0] pid, logic [TIME_W-1:0] rem,
                           logic [TIME_W-1:0] exe);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
      gap++;
    end
    in_valid = 1'b1;
    in_cmd = c;
    in_process_id = pid;
    in_remaining_time = rem;
    in_execution_time = exe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (c)
      CMD_ENQ: begin
        n_enq++;
        if (fill_level >= DEPTH) n_full_tries++;
        else fill_level++;
      end
      CMD_DEQ: begin
        n_deq++;
        if (fill_level == 0) n_empty_tries++;
        else fill_level--;
      end
      default: n_sort++;
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ENQ;
    in_process_id = '0;
    in_remaining_time = '0;
    in_execution_time = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    walk = WALK_FILL;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty queue: sorts do nothing, dequeue flags an error
    issue_cmd(CMD_SORT_REM, '1, '1, '1);
    issue_cmd(CMD_SORT_EXE, '1, '1, '1);
    issue_cmd(CMD_DEQ, '1, '1, '1);
    // Single record: sorts leave it alone, then all-zero record round trip
    issue_cmd(CMD_ENQ, '0, '0, '0);
    issue_cmd(CMD_SORT_REM, '0, '0, '0);
    issue_cmd(CMD_SORT_EXE, '0, '0, '0);
    issue_cmd(CMD_DEQ, '0, '0, '0);
    // Ties on remaining time, on remaining time and id, and field extremes
    issue_cmd(CMD_ENQ, '1, '1, '1);
    issue_cmd(CMD_ENQ, 16'h1234, 32'd5, 32'd100);
    issue_cmd(CMD_ENQ, 16'h0010, 32'd5, 32'd100);
    issue_cmd(CMD_ENQ, 16'h0010, 32'd5, 32'd7);
    issue_cmd(CMD_ENQ, 16'h0001, 32'd0, '1);
    issue_cmd(CMD_ENQ, 16'h8000, '1, '0);
    issue_cmd(CMD_SORT_REM, '0, '0, '0);
    issue_cmd(CMD_SORT_EXE, '0, '0, '0);
    issue_cmd(CMD_DEQ, '0, '0, '0);
    issue_cmd(CMD_DEQ, '0, '0, '0);
    issue_cmd(CMD_SORT_REM, '0, '0, '0);
    repeat (4) issue_cmd(CMD_DEQ, '0, '0, '0);
    issue_cmd(CMD_DEQ, '0, '0, '0);

    // Random walk over the fill level under each idle and stall mix
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct = tx_phase_pct[phase];
      rx_stall_pct = rx_phase_pct[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (walk == WALK_FILL && fill_level == DEPTH && $urandom_range(0, 2) == 0) begin
          walk = WALK_DRAIN;
        end else if (walk == WALK_DRAIN && fill_level == 0 &&
                     $urandom_range(0, 2) == 0) begin
          walk = WALK_FILL;
        end else if ($urandom_range(0, 59) == 0) begin
          walk = walk_t'($urandom_range(0, 2));
        end
        issue_cmd(pick_cmd(walk), pick_pid(), pick_time(), pick_time());
      end
    end

    // Drain: drop valid, release the result channel, let the block settle
    in_valid = 1'b0;
    rx_stall_pct = 0;
    while (results_owed != 0) @(negedge clk);
    repeat (2 * DEPTH + 8) @(negedge clk);

    $display("Covered %0d enqueues (%0d into a full queue), %0d dequeues (%0d from empty)",
             n_enq, n_full_tries, n_deq, n_empty_tries);
    $display("and %0d sorts over four idle/stall mixes in %0d cycles", n_sort, cycle_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
